// ===== hw/rtl/lusp_pkg.sv =====
// Package for the LU solver with partial pivoting.
// Types, codes and fixed-point helpers shared by lusp_div and the top level.
// No dependencies.
`timescale 1ns / 1ps

package lusp_pkg;

    localparam int N_MAX_DEF     = 16;
    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int SIZE_W        = 5;
    localparam int THR_W         = 31;
    localparam int CFG_IDX_W     = 1;

    typedef enum logic [1:0] {
        ACT_LOAD_A = 2'd0,
        ACT_LOAD_B = 2'd1,
        ACT_SOLVE  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MATRIX_SIZE = 1'b0,
        REG_THRESHOLD   = 1'b1
    } cfg_reg_t;

    localparam logic ST_SOLVED   = 1'b0;
    localparam logic ST_SINGULAR = 1'b1;

    typedef struct packed {
        logic [1:0]               action;
        logic [3:0]               row;
        logic [3:0]               col;
        logic signed [WORD_W-1:0] value;
    } command_t;

    typedef struct packed {
        logic [3:0]               index;
        logic signed [WORD_W-1:0] solution;
        logic                     last;
        logic                     status;
    } result_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_COPY_RD, S_COPY_WR,
        S_PIV_RD, S_PIV_CMP, S_SWAP1, S_SWAP2, S_SWAP3,
        S_EL_RD, S_EL_GO, S_EL_WAIT,
        S_K_RD_U, S_K_RD_A, S_K_SUB,
        S_DIAG_RD, S_DIAG_CHK,
        S_FW_INIT, S_FW_RD, S_FW_MUL, S_FW_SUB, S_FW_STORE,
        S_BK_INIT, S_BK_RD, S_BK_MUL, S_BK_SUB, S_BK_DRD, S_BK_GO, S_BK_WAIT,
        S_OUT, S_SING
    } state_t;

    function automatic logic [WORD_W-1:0] mag32(input logic signed [WORD_W-1:0] v);
        mag32 = v[WORD_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi)
            sat32 = 32'sh7FFF_FFFF;
        else if (v < lo)
            sat32 = 32'sh8000_0000;
        else
            sat32 = v[WORD_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/lusp_div.sv =====
// Iterative restoring divider: (num * 2^FRAC_BITS) / den, truncated, saturated.
// One quotient bit per cycle. Depends on lusp_pkg.
`timescale 1ns / 1ps

module lusp_div
    import lusp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [WORD_W-1:0] num,
    input  logic signed [WORD_W-1:0] den,
    output logic                     busy,
    output logic                     done,
    output logic signed [WORD_W-1:0] quot
);

    localparam int NW  = WORD_W + FRAC_BITS;
    localparam int CNW = $clog2(NW + 1);
    localparam logic [NW-1:0] LIM_POS = NW'(64'h7FFF_FFFF);
    localparam logic [NW-1:0] LIM_NEG = NW'(64'h8000_0000);

    logic [NW-1:0]     num_reg;
    logic [NW-1:0]     q_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] den_reg;
    logic              neg_reg;
    logic [CNW-1:0]    cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic signed [WORD_W-1:0] quot_reg;

    logic [WORD_W:0]   trial;
    logic              fits;
    logic [NW-1:0]     q_neg;

    assign trial = {rem_reg, num_reg[NW-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign q_neg = ~q_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNW'(NW);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            num_reg <= {mag32(num), {FRAC_BITS{1'b0}}};
            den_reg <= mag32(den);
            rem_reg <= '0;
            q_reg   <= '0;
            neg_reg <= num[WORD_W-1] ^ den[WORD_W-1];
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                num_reg <= {num_reg[NW-2:0], 1'b0};
                q_reg   <= {q_reg[NW-2:0], fits};
                rem_reg <= fits ? WORD_W'(trial - {1'b0, den_reg}) : trial[WORD_W-1:0];
            end
            else if (neg_reg)
                quot_reg <= (q_reg > LIM_NEG) ? 32'sh8000_0000 : q_neg[WORD_W-1:0];
            else
                quot_reg <= (q_reg > LIM_POS) ? 32'sh7FFF_FFFF : q_reg[WORD_W-1:0];
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== hw/rtl/lu_solve_partial_pivot.sv =====
// LU solve with partial pivoting: each load writes one word while idle; a solve copies
// the matrix, searches each pivot column, eliminates below it with multiply-subtracts,
// divides (n^2+n)/2 times and runs forward and back substitution, then gives n words,
// one word per cycle, or one singular word. The bit-serial divider dominates up to n=16.
// Reset: size 16, threshold 0, row order identity, stores undefined until written.
// Results cannot be stalled; busy is high for the whole solve.
`timescale 1ns / 1ps

module lu_solve_partial_pivot
    import lusp_pkg::*;
#(
    parameter int N_MAX     = N_MAX_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  command_t             command,
    output logic                 result_valid,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [THR_W-1:0]     cfg_data
);

    localparam int IW = $clog2(N_MAX);
    localparam int CW = $clog2(N_MAX + 1);
    localparam int AW = 2 * IW;

    logic signed [WORD_W-1:0] mstore [1 << AW];
    logic signed [WORD_W-1:0] work   [1 << AW];
    logic signed [WORD_W-1:0] vstore [1 << IW];
    logic signed [WORD_W-1:0] vec    [1 << IW];
    logic [IW-1:0]            perm   [1 << IW];

    state_t state_reg, state_next;
    logic [CW-1:0] ci_reg, ci_next, cj_reg, cj_next, ck_reg, ck_next, n_reg, n_next;
    logic [CW-1:0] prow_reg, prow_next;
    logic [SIZE_W-1:0] size_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [WORD_W-1:0] best_reg, best_next;
    logic signed [WORD_W-1:0] pval_reg, pval_next, f_reg, f_next, acc_reg, acc_next;
    logic signed [63:0] prod_reg, prod_next;
    logic [IW-1:0] tmp_reg, tmp_next;
    logic    res_valid_reg, res_valid_next;
    result_t res_reg, res_next;

    logic signed [WORD_W-1:0] mx_q, wk_q, vec_q;
    logic [AW-1:0] wk_raddr, wk_waddr;
    logic          wk_we;
    logic signed [WORD_W-1:0] wk_wdata;
    logic [IW-1:0] perm_idx, perm_q, perm_wa, perm_wd, vec_idx;
    logic          perm_we, vec_we;
    logic signed [WORD_W-1:0] vec_wd;
    logic          div_start, div_busy, div_done;
    logic signed [WORD_W-1:0] div_num, div_den, div_q;
    logic signed [WORD_W-1:0] fx_m, sub_a, diff;
    logic [CW-1:0] n_use, n_m1;
    logic [WORD_W-1:0] m_cur;
    logic          load_ok;

    lusp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_q)
    );

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    assign load_ok = (int'(command.row) < N_MAX) && (int'(command.col) < N_MAX);
    assign n_m1    = n_reg - 1'b1;
    assign perm_q  = perm[perm_idx];
    assign vec_q   = vec[vec_idx];
    assign m_cur   = mag32(wk_q);
    assign fx_m    = sat32(prod_reg >>> FRAC_BITS);
    assign sub_a   = (state_reg == S_K_SUB) ? wk_q : acc_reg;
    assign diff    = sat32(64'(sub_a) - 64'(fx_m));

    always_comb
    begin
        if (size_reg == '0)
            n_use = CW'(1);
        else if (int'(size_reg) > N_MAX)
            n_use = CW'(N_MAX);
        else
            n_use = CW'(size_reg);
    end

    // stores
    always_ff @(posedge clk)
    begin
        if (start && !busy && command.action == ACT_LOAD_A && load_ok)
            mstore[{IW'(command.row), IW'(command.col)}] <= command.value;
        if (start && !busy && command.action == ACT_LOAD_B && int'(command.row) < N_MAX)
            vstore[IW'(command.row)] <= command.value;
        mx_q <= mstore[{ci_reg[IW-1:0], cj_reg[IW-1:0]}];
        wk_q <= work[wk_raddr];
        if (wk_we)
            work[wk_waddr] <= wk_wdata;
        if (vec_we)
            vec[ci_reg[IW-1:0]] <= vec_wd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < (1 << IW); i++)
                perm[i] <= IW'(i);
        end
        else if (perm_we)
            perm[perm_wa] <= perm_wd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            size_reg      <= SIZE_W'(16);
            thr_reg       <= '0;
            res_valid_reg <= 1'b0;
            ci_reg        <= '0;
            cj_reg        <= '0;
            ck_reg        <= '0;
            n_reg         <= CW'(1);
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            ci_reg        <= ci_next;
            cj_reg        <= cj_next;
            ck_reg        <= ck_next;
            n_reg         <= n_next;
            if (cfg_we && cfg_index == REG_MATRIX_SIZE)
                size_reg <= cfg_data[SIZE_W-1:0];
            if (cfg_we && cfg_index == REG_THRESHOLD)
                thr_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        prow_reg <= prow_next;
        best_reg <= best_next;
        pval_reg <= pval_next;
        f_reg    <= f_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        tmp_reg  <= tmp_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        ci_next        = ci_reg;
        cj_next        = cj_reg;
        ck_next        = ck_reg;
        n_next         = n_reg;
        prow_next      = prow_reg;
        best_next      = best_reg;
        pval_next      = pval_reg;
        f_next         = f_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        tmp_next       = tmp_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        perm_idx       = ci_reg[IW-1:0];
        vec_idx        = ci_reg[IW-1:0];
        wk_raddr       = {perm_q, ci_reg[IW-1:0]};
        wk_we          = 1'b0;
        wk_waddr       = {ci_reg[IW-1:0], cj_reg[IW-1:0]};
        wk_wdata       = mx_q;
        perm_we        = 1'b0;
        perm_wa        = ci_reg[IW-1:0];
        perm_wd        = ci_reg[IW-1:0];
        vec_we         = 1'b0;
        vec_wd         = acc_reg;
        div_start      = 1'b0;
        div_num        = wk_q;
        div_den        = pval_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start && command.action == ACT_SOLVE)
                begin
                    n_next     = n_use;
                    ci_next    = '0;
                    cj_next    = '0;
                    state_next = S_COPY_RD;
                end
            end
            S_COPY_RD:
                state_next = S_COPY_WR;
            S_COPY_WR:
            begin
                wk_we = 1'b1;
                if (cj_reg == '0)
                    perm_we = 1'b1;
                state_next = S_COPY_RD;
                if (cj_reg == n_m1)
                begin
                    cj_next = '0;
                    if (ci_reg == n_m1)
                    begin
                        ci_next    = '0;
                        state_next = (n_reg == CW'(1)) ? S_DIAG_RD : S_PIV_RD;
                    end
                    else
                        ci_next = ci_reg + 1'b1;
                end
                else
                    cj_next = cj_reg + 1'b1;
            end
            S_PIV_RD:
            begin
                perm_idx   = cj_reg[IW-1:0];
                wk_raddr   = {perm_q, ci_reg[IW-1:0]};
                state_next = S_PIV_CMP;
            end
            S_PIV_CMP:
            begin
                if (cj_reg == ci_reg || m_cur > best_reg)
                begin
                    best_next = m_cur;
                    pval_next = wk_q;
                    prow_next = cj_reg;
                end
                if (cj_reg == n_m1)
                    state_next = S_SWAP1;
                else
                begin
                    cj_next    = cj_reg + 1'b1;
                    state_next = S_PIV_RD;
                end
            end
            S_SWAP1:
            begin
                tmp_next   = perm_q;
                state_next = (best_reg <= {1'b0, thr_reg}) ? S_SING : S_SWAP2;
            end
            S_SWAP2:
            begin
                perm_idx   = prow_reg[IW-1:0];
                perm_we    = 1'b1;
                perm_wd    = perm_q;
                state_next = S_SWAP3;
            end
            S_SWAP3:
            begin
                perm_we    = 1'b1;
                perm_wa    = prow_reg[IW-1:0];
                perm_wd    = tmp_reg;
                cj_next    = ci_reg + 1'b1;
                state_next = S_EL_RD;
            end
            S_EL_RD:
            begin
                perm_idx   = cj_reg[IW-1:0];
                wk_raddr   = {perm_q, ci_reg[IW-1:0]};
                state_next = S_EL_GO;
            end
            S_EL_GO:
            begin
                div_start  = 1'b1;
                state_next = S_EL_WAIT;
            end
            S_EL_WAIT:
            begin
                perm_idx = cj_reg[IW-1:0];
                wk_waddr = {perm_q, ci_reg[IW-1:0]};
                wk_wdata = div_q;
                if (div_done)
                begin
                    wk_we      = 1'b1;
                    f_next     = div_q;
                    ck_next    = ci_reg + 1'b1;
                    state_next = S_K_RD_U;
                end
            end
            S_K_RD_U:
            begin
                wk_raddr   = {perm_q, ck_reg[IW-1:0]};
                state_next = S_K_RD_A;
            end
            S_K_RD_A:
            begin
                perm_idx   = cj_reg[IW-1:0];
                wk_raddr   = {perm_q, ck_reg[IW-1:0]};
                prod_next  = 64'(f_reg) * 64'(wk_q);
                state_next = S_K_SUB;
            end
            S_K_SUB:
            begin
                perm_idx = cj_reg[IW-1:0];
                wk_we    = 1'b1;
                wk_waddr = {perm_q, ck_reg[IW-1:0]};
                wk_wdata = diff;
                if (ck_reg != n_m1)
                begin
                    ck_next    = ck_reg + 1'b1;
                    state_next = S_K_RD_U;
                end
                else if (cj_reg != n_m1)
                begin
                    cj_next    = cj_reg + 1'b1;
                    state_next = S_EL_RD;
                end
                else
                begin
                    ci_next    = ci_reg + 1'b1;
                    cj_next    = ci_reg + 1'b1;
                    state_next = (ci_reg == n_reg - CW'(2)) ? S_DIAG_RD : S_PIV_RD;
                end
            end
            S_DIAG_RD:
            begin
                wk_raddr   = {perm_q, ci_reg[IW-1:0]};
                state_next = S_DIAG_CHK;
            end
            S_DIAG_CHK:
            begin
                ci_next    = '0;
                state_next = (m_cur <= {1'b0, thr_reg}) ? S_SING : S_FW_INIT;
            end
            S_FW_INIT:
            begin
                acc_next   = vstore[perm_q];
                cj_next    = '0;
                state_next = (ci_reg == '0) ? S_FW_STORE : S_FW_RD;
            end
            S_FW_RD, S_BK_RD:
            begin
                wk_raddr   = {perm_q, cj_reg[IW-1:0]};
                state_next = (state_reg == S_FW_RD) ? S_FW_MUL : S_BK_MUL;
            end
            S_FW_MUL, S_BK_MUL:
            begin
                vec_idx    = cj_reg[IW-1:0];
                prod_next  = 64'(wk_q) * 64'(vec_q);
                state_next = (state_reg == S_FW_MUL) ? S_FW_SUB : S_BK_SUB;
            end
            S_FW_SUB:
            begin
                acc_next = diff;
                if (cj_reg == ci_reg - 1'b1)
                    state_next = S_FW_STORE;
                else
                begin
                    cj_next    = cj_reg + 1'b1;
                    state_next = S_FW_RD;
                end
            end
            S_FW_STORE:
            begin
                vec_we = 1'b1;
                if (ci_reg == n_m1)
                    state_next = S_BK_INIT;
                else
                begin
                    ci_next    = ci_reg + 1'b1;
                    state_next = S_FW_INIT;
                end
            end
            S_BK_INIT:
            begin
                acc_next   = vec_q;
                cj_next    = ci_reg + 1'b1;
                state_next = (ci_reg == n_m1) ? S_BK_DRD : S_BK_RD;
            end
            S_BK_SUB:
            begin
                acc_next = diff;
                if (cj_reg == n_m1)
                    state_next = S_BK_DRD;
                else
                begin
                    cj_next    = cj_reg + 1'b1;
                    state_next = S_BK_RD;
                end
            end
            S_BK_DRD:
            begin
                wk_raddr   = {perm_q, ci_reg[IW-1:0]};
                state_next = S_BK_GO;
            end
            S_BK_GO:
            begin
                div_start  = 1'b1;
                div_num    = acc_reg;
                div_den    = wk_q;
                state_next = S_BK_WAIT;
            end
            S_BK_WAIT:
            begin
                vec_wd = div_q;
                if (div_done)
                begin
                    vec_we = 1'b1;
                    if (ci_reg == '0)
                        state_next = S_OUT;
                    else
                    begin
                        ci_next    = ci_reg - 1'b1;
                        state_next = S_BK_INIT;
                    end
                end
            end
            S_OUT:
            begin
                res_valid_next    = 1'b1;
                res_next.index    = 4'(ci_reg);
                res_next.solution = vec_q;
                res_next.last     = (ci_reg == n_m1);
                res_next.status   = ST_SOLVED;
                if (ci_reg == n_m1)
                    state_next = S_IDLE;
                else
                    ci_next = ci_reg + 1'b1;
            end
            S_SING:
            begin
                res_valid_next    = 1'b1;
                res_next.index    = '0;
                res_next.solution = '0;
                res_next.last     = 1'b1;
                res_next.status   = ST_SINGULAR;
                state_next        = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |=> !result_valid)
        else $error("word after last");

    a_sing_form: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_SINGULAR |-> result.last && result.index == '0)
        else $error("bad singular word");

    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && ci_reg == n_m1 |=> !busy)
        else $error("solve did not end after last word");

endmodule

// ===== dv/tb_top.sv =====
// Testbench for lu_solve_partial_pivot: loads and solves with an in-bench
// fixed-point predictor, checks every result word in order.
// Depends on lusp_pkg and the lu_solve_partial_pivot RTL.
`timescale 1ns / 1ps

module tb_top;
    import lusp_pkg::*;

    localparam int      NM        = 16;
    localparam int      FB        = 16;
    localparam longint  MAX_CYCLES = 2_000_000;

    logic         clk;
    logic         rst_n;
    logic         start;
    logic         busy;
    command_t     command;
    logic         result_valid;
    result_t      result;
    logic         cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [THR_W-1:0]     cfg_data;

    lu_solve_partial_pivot i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    logic signed [31:0] mat_q [NM][NM];
    logic signed [31:0] rhs_q [NM];
    bit                 mat_wr [NM][NM];
    bit                 rhs_wr [NM];
    logic [4:0]         size_q;
    logic [30:0]        thr_q;
    result_t            solution_q [$];
    int                 mismatches;
    longint             cycles;
    bit                 quiet;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic signed [31:0] sat(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fmul(logic signed [31:0] a, logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return sat(p >>> FB);
    endfunction

    function automatic logic signed [31:0] fsub(logic signed [31:0] a, logic signed [31:0] b);
        return sat(longint'(a) - longint'(b));
    endfunction

    function automatic logic signed [31:0] fdiv(logic signed [31:0] a, logic signed [31:0] b);
        longint num;
        num = longint'(a) * (64'sd1 <<< FB);
        if (b == 0)
            return 0;
        return sat(num / longint'(b));
    endfunction

    function automatic longint magn(logic signed [31:0] v);
        longint w;
        w = longint'(v);
        return (w < 0) ? -w : w;
    endfunction

    function automatic int size_used();
        if (size_q == 0)
            return 1;
        if (size_q > NM)
            return NM;
        return int'(size_q);
    endfunction

    function automatic void predict_solve();
        logic signed [31:0] w [NM][NM];
        logic signed [31:0] v [NM];
        logic signed [31:0] t;
        logic signed [31:0] f;
        int      perm [NM];
        int      n;
        int      prow;
        int      tp;
        longint  best;
        longint  m;
        bit      sing;
        result_t r;
        n = size_used();
        sing = 0;
        for (int i = 0; i < n; i++)
        begin
            for (int j = 0; j < n; j++)
                w[i][j] = mat_q[i][j];
            perm[i] = i;
        end
        for (int i = 0; i + 1 < n && !sing; i++)
        begin
            prow = i;
            best = magn(w[i][i]);
            for (int j = i + 1; j < n; j++)
            begin
                m = magn(w[j][i]);
                if (m > best)
                begin
                    best = m;
                    prow = j;
                end
            end
            if (best <= longint'(thr_q))
                sing = 1;
            else
            begin
                if (prow != i)
                begin
                    for (int k = 0; k < NM; k++)
                    begin
                        t = w[i][k];
                        w[i][k] = w[prow][k];
                        w[prow][k] = t;
                    end
                    tp = perm[i];
                    perm[i] = perm[prow];
                    perm[prow] = tp;
                end
                for (int j = i + 1; j < n; j++)
                begin
                    f = fdiv(w[j][i], w[i][i]);
                    w[j][i] = f;
                    for (int k = i + 1; k < n; k++)
                        w[j][k] = fsub(w[j][k], fmul(f, w[i][k]));
                end
            end
        end
        if (!sing && magn(w[n-1][n-1]) <= longint'(thr_q))
            sing = 1;
        if (sing)
        begin
            r.index = 0;
            r.solution = 0;
            r.last = 1'b1;
            r.status = ST_SINGULAR;
            solution_q.push_back(r);
            return;
        end
        for (int i = 0; i < n; i++)
        begin
            t = rhs_q[perm[i]];
            for (int j = 0; j < i; j++)
                t = fsub(t, fmul(w[i][j], v[j]));
            v[i] = t;
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            t = v[i];
            for (int j = i + 1; j < n; j++)
                t = fsub(t, fmul(w[i][j], v[j]));
            v[i] = fdiv(t, w[i][i]);
        end
        for (int i = 0; i < n; i++)
        begin
            r.index = 4'(i);
            r.solution = v[i];
            r.last = (i == n - 1);
            r.status = ST_SOLVED;
            solution_q.push_back(r);
        end
    endfunction

    function automatic void apply_word(command_t c);
        case (action_t'(c.action))
            ACT_LOAD_A:
            begin
                mat_q[c.row][c.col] = c.value;
                mat_wr[c.row][c.col] = 1;
            end
            ACT_LOAD_B:
            begin
                rhs_q[c.row] = c.value;
                rhs_wr[c.row] = 1;
            end
            ACT_SOLVE:
                predict_solve();
            default:
                ;
        endcase
    endfunction

    // result checker
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && result_valid)
        begin
            if (solution_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: idx %0d x %0d last %0b st %0b",
                             result.index, result.solution, result.last, result.status);
            end
            else
            begin
                e = solution_q.pop_front();
                if (result.index !== e.index || result.solution !== e.solution ||
                    result.last !== e.last || result.status !== e.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp idx %0d x %0d last %0b st %0b, ",
                                  "got idx %0d x %0d last %0b st %0b"},
                                 e.index, e.solution, e.last, e.status,
                                 result.index, result.solution, result.last, result.status);
                end
            end
        end
    end

    task automatic send(input logic [1:0] act, input int r, input int c,
                        input logic signed [31:0] val);
        command_t cmd;
        cmd.action = act;
        cmd.row = 4'(r);
        cmd.col = 4'(c);
        cmd.value = val;
        if (!quiet)
            while ($urandom_range(99) < 18)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        start <= 1'b1;
        command <= cmd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        apply_word(cmd);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (solution_q.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [30:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_MATRIX_SIZE)
            size_q = val[4:0];
        else
            thr_q = val;
    endtask

    function automatic logic signed [31:0] rand_value();
        if ($urandom_range(99) < 75)
            return $signed(32'($urandom_range(0, 32'h000C_0000))) - 32'sh0006_0000;
        return $urandom;
    endfunction

    task automatic fill_missing(input int n);
        for (int r = 0; r < n; r++)
        begin
            for (int c = 0; c < n; c++)
                if (!mat_wr[r][c])
                    send(ACT_LOAD_A, r, c, rand_value());
            if (!rhs_wr[r])
                send(ACT_LOAD_B, r, 0, rand_value());
        end
    endtask

    task automatic test_size_one();
        write_reg(REG_MATRIX_SIZE, 31'd0);
        write_reg(REG_THRESHOLD, 31'd0);
        send(ACT_LOAD_A, 0, 0, 32'sh0002_0000);
        send(ACT_LOAD_B, 0, 0, 32'sh0001_0000);
        send(ACT_SOLVE, 0, 0, 0);
        send(ACT_LOAD_A, 0, 0, 32'sh8000_0000);
        send(ACT_LOAD_B, 0, 0, 32'sh7FFF_FFFF);
        send(ACT_SOLVE, 0, 0, 0);
        send(ACT_NONE, 15, 15, 32'sh7FFF_FFFF);
        send(ACT_LOAD_A, 0, 0, 32'sh7FFF_FFFF);
        send(ACT_LOAD_B, 0, 0, 32'sh8000_0000);
        send(ACT_SOLVE, 0, 0, 0);
        send(ACT_LOAD_A, 0, 0, 0);
        send(ACT_SOLVE, 0, 0, 0);
        drain();
    endtask

    task automatic test_pivot_swap();
        write_reg(REG_MATRIX_SIZE, 31'd2);
        send(ACT_LOAD_A, 0, 0, 0);
        send(ACT_LOAD_A, 0, 1, 32'sh0001_0000);
        send(ACT_LOAD_A, 1, 0, -32'sh0003_0000);
        send(ACT_LOAD_A, 1, 1, 32'sh0000_8000);
        send(ACT_LOAD_B, 0, 0, 32'sh0002_0000);
        send(ACT_LOAD_B, 1, 0, -32'sh0001_0000);
        send(ACT_SOLVE, 0, 0, 0);
        send(ACT_SOLVE, 0, 0, 0);
        drain();
    endtask

    task automatic test_threshold_extremes();
        write_reg(REG_THRESHOLD, 31'h7FFF_FFFF);
        send(ACT_SOLVE, 0, 0, 0);
        drain();
        write_reg(REG_THRESHOLD, 31'h0003_0000);
        send(ACT_SOLVE, 0, 0, 0);
        drain();
        write_reg(REG_THRESHOLD, 31'd0);
    endtask

    task automatic test_random();
        int n;
        int pick;
        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            quiet = (ph == 2);
            pick = $urandom_range(9);
            write_reg(REG_MATRIX_SIZE, (pick == 0) ? 31'd0 : 31'($urandom_range(1, 5)));
            write_reg(REG_THRESHOLD, ($urandom_range(1)) ? 31'd0 : 31'($urandom_range(0, 31'h800)));
            n = size_used();
            fill_missing(n);
            for (int it = 0; it < 15; it++)
            begin
                pick = $urandom_range(99);
                if (pick < 50)
                    send(ACT_LOAD_A, $urandom_range(n - 1), $urandom_range(n - 1), rand_value());
                else if (pick < 65)
                    send(ACT_LOAD_B, $urandom_range(n - 1), $urandom_range(15), rand_value());
                else if (pick < 72)
                    send(ACT_NONE, $urandom_range(15), $urandom_range(15), $urandom);
                else
                    send(ACT_SOLVE, $urandom_range(15), $urandom_range(15), $urandom);
            end
        end
        quiet = 0;
        drain();
    endtask

    task automatic test_large_size();
        write_reg(REG_MATRIX_SIZE, 31'd8);
        fill_missing(8);
        send(ACT_SOLVE, 0, 0, 0);
        drain();
        send(ACT_LOAD_A, 7, 7, 32'sh7FFF_FFFF);
        send(ACT_LOAD_B, 7, 0, 32'sh8000_0000);
        send(ACT_LOAD_A, 15, 15, 32'sh0001_0000);
        send(ACT_SOLVE, 0, 0, 0);
        drain();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        command <= '0;
        cfg_we <= 1'b0;
        cfg_index <= REG_MATRIX_SIZE;
        cfg_data <= '0;
        cycles = 0;
        mismatches = 0;
        quiet = 0;
        size_q = 5'd16;
        thr_q = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_size_one();
        test_pivot_swap();
        test_threshold_extremes();
        test_random();
        test_large_size();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && solution_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
